>>> sv/ctp_pkg.sv
// ----------------------------------------------------------------------------
// ctp_pkg
// Shared types and constants for the countdown timer pool.
// ----------------------------------------------------------------------------
package ctp_pkg;

    localparam int CNT_W         = 32;
    localparam int IDX_W         = 4;
    localparam int CMD_W         = 2;
    localparam int NUM_SLOTS_DEF = 8;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 2'd0,
        CMD_ALLOC   = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_QUERY   = 2'd3
    } t_cmd;

    // per-cell control for one accepted word
    typedef struct packed {
        logic tick;   // decrement nonzero counter
        logic alloc;  // allocate request travels down the chain
        logic clear;  // release addressed to this cell
    } t_cell_ctl;

endpackage

>>> sv/ctp_cell.sv
// ----------------------------------------------------------------------------
// ctp_cell
// One timer slot: busy mark and countdown counter, with a link in the
// free-slot priority chain that runs from slot 0 upward.
// ----------------------------------------------------------------------------
module ctp_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ctp_pkg::t_cell_ctl          i_ctl,
    input  logic [ctp_pkg::CNT_W-1:0]   i_load,
    input  logic                        i_free_in,
    output logic                        o_free_out,
    output logic                        o_grant,
    output logic [ctp_pkg::CNT_W-1:0]   o_count
);

    logic                      r_used;
    logic                      n_used;
    logic [ctp_pkg::CNT_W-1:0] r_count;
    logic [ctp_pkg::CNT_W-1:0] n_count;

    // priority chain: first free cell takes the allocation
    assign o_grant    = i_ctl.alloc & ~i_free_in & ~r_used;
    assign o_free_out = i_free_in | ~r_used;
    assign o_count    = r_count;

    // next slot state
    always_comb begin
        n_used  = r_used;
        n_count = r_count;
        if (i_ctl.tick) begin
            if (r_count != '0) begin
                n_count = r_count - 1'b1;
            end
        end else if (o_grant) begin
            n_used  = 1'b1;
            n_count = i_load;
        end else if (i_ctl.clear) begin
            n_used  = 1'b0;
            n_count = '0;
        end
    end

    // slot registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= 1'b0;
            r_count <= '0;
        end else begin
            r_used  <= n_used;
            r_count <= n_count;
        end
    end

endmodule

>>> sv/countdown_timer_pool.sv
// ----------------------------------------------------------------------------
// countdown_timer_pool
// Pool of countdown timer slots built as a chain of slot cells.
// ----------------------------------------------------------------------------
// The result strobe o_valid is registered and rises in the cycle after the
// command is taken. One command per cycle; busy stays low and every command
// is taken when offered, as the free-slot chain is combinational.
// Results are shown for one cycle only; the receiver cannot stall.
// Reset (synchronous, active low) frees all slots, zeroes all counters and
// the tick total, and drops o_valid.
module countdown_timer_pool #(
    parameter int NUM_SLOTS = ctp_pkg::NUM_SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ctp_pkg::CMD_W-1:0]   i_cmd,
    input  logic [ctp_pkg::CNT_W-1:0]   i_load_ticks,
    input  logic [ctp_pkg::IDX_W-1:0]   i_slot_index,
    output logic                        o_valid,
    output logic                        o_ok,
    output logic [ctp_pkg::IDX_W-1:0]   o_slot_granted,
    output logic [ctp_pkg::CNT_W-1:0]   o_remaining,
    output logic                        o_timed_out,
    output logic [ctp_pkg::CNT_W-1:0]   o_tick_total
);

    ctp_pkg::t_cmd              w_cmd;
    logic                       w_accept;
    logic                       w_idx_ok;
    ctp_pkg::t_cell_ctl         w_ctl   [NUM_SLOTS];
    logic [NUM_SLOTS:0]         w_free;
    logic [NUM_SLOTS-1:0]       w_grant;
    logic [ctp_pkg::CNT_W-1:0]  w_count [NUM_SLOTS];
    logic [ctp_pkg::CNT_W-1:0]  w_sel_count;
    logic [ctp_pkg::IDX_W-1:0]  w_grant_idx;

    logic                       r_valid;
    logic                       r_ok;
    logic [ctp_pkg::IDX_W-1:0]  r_granted;
    logic [ctp_pkg::CNT_W-1:0]  r_remaining;
    logic                       r_timed_out;
    logic [ctp_pkg::CNT_W-1:0]  r_tick;

    logic                       n_ok;
    logic [ctp_pkg::IDX_W-1:0]  n_granted;
    logic [ctp_pkg::CNT_W-1:0]  n_remaining;
    logic                       n_timed_out;
    logic [ctp_pkg::CNT_W-1:0]  n_tick;

    // busy is tied low: no command ever waits
    assign busy     = 1'b0;
    assign w_accept = start & ~busy;
    assign w_cmd    = ctp_pkg::t_cmd'(i_cmd);
    assign w_idx_ok = ({1'b0, i_slot_index} < (ctp_pkg::IDX_W + 1)'(NUM_SLOTS));

    // slot cells, free chain enters at slot 0
    assign w_free[0] = 1'b0;

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        always_comb begin
            w_ctl[g].tick  = w_accept && (w_cmd == ctp_pkg::CMD_TICK);
            w_ctl[g].alloc = w_accept && (w_cmd == ctp_pkg::CMD_ALLOC);
            w_ctl[g].clear = w_accept && (w_cmd == ctp_pkg::CMD_RELEASE)
                             && (i_slot_index == ctp_pkg::IDX_W'(g));
        end

        ctp_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl[g]),
            .i_load     (i_load_ticks),
            .i_free_in  (w_free[g]),
            .o_free_out (w_free[g+1]),
            .o_grant    (w_grant[g]),
            .o_count    (w_count[g])
        );
    end

    // addressed slot counter and granted slot number
    always_comb begin
        w_sel_count = '0;
        w_grant_idx = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (i_slot_index == ctp_pkg::IDX_W'(i)) begin
                w_sel_count = w_sel_count | w_count[i];
            end
            if (w_grant[i]) begin
                w_grant_idx = w_grant_idx | ctp_pkg::IDX_W'(i);
            end
        end
    end

    // result word for the command
    always_comb begin
        n_ok        = 1'b0;
        n_granted   = '0;
        n_remaining = '0;
        n_timed_out = 1'b0;
        n_tick      = r_tick;
        unique case (w_cmd)
            ctp_pkg::CMD_TICK: begin
                n_tick = r_tick + 1'b1;
            end
            ctp_pkg::CMD_ALLOC: begin
                n_ok      = w_free[NUM_SLOTS];
                n_granted = w_grant_idx;
            end
            ctp_pkg::CMD_RELEASE: begin
                n_ok        = w_idx_ok;
                n_remaining = w_idx_ok ? w_sel_count : '1;
            end
            ctp_pkg::CMD_QUERY: begin
                n_ok        = w_idx_ok;
                n_timed_out = w_idx_ok && (w_sel_count == '0);
            end
            default: begin
                n_tick = r_tick;
            end
        endcase
    end

    // control and tick total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tick  <= '0;
        end else begin
            r_valid <= w_accept;
            if (w_accept) begin
                r_tick <= n_tick;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ok        <= n_ok;
            r_granted   <= n_granted;
            r_remaining <= n_remaining;
            r_timed_out <= n_timed_out;
        end
    end

    assign o_valid        = r_valid;
    assign o_ok           = r_ok;
    assign o_slot_granted = r_granted;
    assign o_remaining    = r_remaining;
    assign o_timed_out    = r_timed_out;
    assign o_tick_total   = r_tick;

`ifndef SYNTHESIS
    // at most one cell takes an allocation
    a_one_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_grant))
        else $error("more than one slot granted");

    // one result word for each accepted command
    a_word_per_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (o_valid == $past(w_accept)))
        else $error("result strobe does not follow accepted command");

    // a failed command carries no grant and no timeout
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_slot_granted == '0 && !o_timed_out))
        else $error("failed result carries grant or timeout");

    // tick advances the total by one
    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_cmd == ctp_pkg::CMD_TICK) |=> (r_tick == $past(r_tick) + 1'b1))
        else $error("tick total did not advance");
`endif

endmodule
